### src/particle_drag_integrator_top_defines.svh
// Assertion macros for the particle drag integrator checker.
// Used by pdi_checker; clock and reset are the top level's clk_i and rst_ni.
`ifndef PARTICLE_DRAG_INTEGRATOR_TOP_DEFINES_SVH
`define PARTICLE_DRAG_INTEGRATOR_TOP_DEFINES_SVH

// same-cycle implication
`define PDI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pdi_pkg.sv
// Package for the particle drag integrator: types, codes and fixed-point helpers.
// No dependencies; used by pdi_alu, pdi_seq and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pdi_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int KE_BITS   = 48;
  localparam logic [30:0] WMAX = '1;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_ADD     = 3'd1,
    ACT_CLEAR   = 3'd2,
    ACT_KICK    = 3'd3,
    ACT_SETPOS  = 3'd4,
    ACT_SETVEL  = 3'd5,
    ACT_SETTERM = 3'd6
  } act_e;

  typedef enum logic [2:0] {
    REG_MASS    = 3'd0,
    REG_AREA    = 3'd1,
    REG_DRAG    = 3'd2,
    REG_DENSITY = 3'd3,
    REG_GRAVITY = 3'd4,
    REG_TSTEP   = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_K1, S_K2, S_DS, S_DM, S_DD, S_VX, S_VY, S_PX, S_PY,
    S_KAX, S_KAY, S_TY0, S_TY1, S_TY2, S_XN, S_XD1, S_XD2, S_XSQ,
    S_E1, S_E2, S_E3, S_OUT
  } seq_state_e;

  typedef struct packed {
    logic [30:0] mass;
    logic [30:0] area;
    logic [30:0] drag;
    logic [30:0] density;
    logic [31:0] gravity;
    logic [30:0] tstep;
  } cfg_t;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic [127:0] a;
    logic [63:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] value;
  } alu_res_t;

  typedef struct packed {
    act_e        action;
    logic [31:0] value_x;
    logic [31:0] value_y;
    logic [1:0]  clear_mask;
  } item_t;

  typedef struct packed {
    logic        saturated;
    logic [47:0] kinetic_energy;
    logic [30:0] terminal_y;
    logic [30:0] terminal_x;
    logic [31:0] velocity_y;
    logic [31:0] velocity_x;
    logic [31:0] position_y;
    logic [31:0] position_x;
  } result_t;

  typedef struct packed {
    logic [31:0] w;
    logic        c;
  } wres_t;

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // signed word from sign and magnitude, clipped
  function automatic wres_t to_word(input logic neg, input logic [127:0] m);
    logic [31:0] lim;
    logic [31:0] mg;
    wres_t r;
    lim = 32'h7FFF_FFFF + {31'd0, neg};
    r.c = 1'b0;
    mg  = m[31:0];
    if ((|m[127:32]) || (m[31:0] > lim)) begin
      r.c = 1'b1;
      mg  = lim;
    end
    r.w = neg ? (32'd0 - mg) : mg;
    return r;
  endfunction

  function automatic wres_t sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    wres_t r;
    s = {a[31], a} + {b[31], b};
    r.c = s[32] != s[31];
    r.w = r.c ? (s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : s[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### src/particle_drag_integrator_top.sv
// Top level of the particle drag integrator: config registers, stream ports,
// output register. Depends on pdi_pkg, pdi_seq and pdi_alu.
//
//   channel  direction  fields
//   s_axis   in         tuser: action; tdata: value_x, value_y, clear_mask
//   m_axis   out        tdata: position, velocity, terminal, energy, saturated
//   cfg      in         cfg_idx_i selects register, cfg_wdata_i value
//
// Each request runs through its unit operations, all on the single shared serial
// unit. Tick: 13 multiplies, 2 divides (plus 1 multiply, 1 divide, 1 root while
// terminal y is zero). Kick: 5 multiplies, 2 divides. Set terminal: up to
// 7 multiplies, 3 divides, 2 roots. Others: 3 multiplies.
// s_axis_tready is low from accept until the result moves to the output
// register; a stalled result holds the sequencer. Reset loads the config
// defaults and clears position, velocity, force, terminal speed and output valid.
`timescale 1ns / 1ps
`default_nettype none

module particle_drag_integrator_top
  import pdi_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [71:0]  s_axis_tdata,  // value_x, value_y, clear_mask
  input  wire logic [2:0]   s_axis_tuser,  // action
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // position_x, position_y, velocity_x, velocity_y, terminal_x, terminal_y,
  // kinetic_energy, saturated
  output logic [239:0]      m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_wdata_i
);

  cfg_t     cfg_q;
  item_t    item;
  result_t  res;
  logic     res_valid;
  logic     res_free;
  logic     out_valid_q;
  result_t  out_q;
  alu_req_t alu_req;
  alu_res_t alu_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mass    <= 31'd65536;
      cfg_q.area    <= 31'd65536;
      cfg_q.drag    <= 31'd30802;
      cfg_q.density <= 31'd80282;
      cfg_q.gravity <= 32'd642908;
      cfg_q.tstep   <= 31'd655;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_MASS:    cfg_q.mass    <= cfg_wdata_i[30:0];
        REG_AREA:    cfg_q.area    <= cfg_wdata_i[30:0];
        REG_DRAG:    cfg_q.drag    <= cfg_wdata_i[30:0];
        REG_DENSITY: cfg_q.density <= cfg_wdata_i[30:0];
        REG_GRAVITY: cfg_q.gravity <= cfg_wdata_i;
        REG_TSTEP:   cfg_q.tstep   <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  assign item.action     = act_e'(s_axis_tuser);
  assign item.value_x    = s_axis_tdata[31:0];
  assign item.value_y    = s_axis_tdata[63:32];
  assign item.clear_mask = s_axis_tdata[65:64];

  assign res_free = !out_valid_q || m_axis_tready;

  pdi_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_free_i   (res_free),
    .res_o        (res),
    .alu_req_o    (alu_req),
    .alu_res_i    (alu_res)
  );

  pdi_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .res_o  (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

endmodule

`default_nettype wire

### src/pdi_alu.sv
// Shared serial arithmetic unit: 64x64 multiply, 128/64 divide, 128-bit square root.
// One bit (root: one digit) per cycle. Depends on pdi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdi_alu
  import pdi_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire alu_req_t req_i,
  output alu_res_t      res_o
);

  logic         busy_q, busy_d;
  logic         done_q, done_d;
  alu_op_e      op_q, op_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [127:0] acc_q, acc_d;
  logic [127:0] x_q, x_d;
  logic [63:0]  y_q, y_d;
  logic [67:0]  rem_q, rem_d;

  always_comb begin
    logic [64:0] r2;
    logic [67:0] r4;
    logic [67:0] trial;
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    rem_d  = rem_q;
    r2     = {rem_q[63:0], x_q[127]};
    r4     = {rem_q[65:0], x_q[127:126]};
    trial  = {2'b00, acc_q[63:0], 2'b01};
    if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (y_q[0]) acc_d = acc_q + x_q;
          x_d = x_q << 1;
          y_d = y_q >> 1;
        end
        OP_DIV: begin
          if (r2 >= {1'b0, y_q}) begin
            rem_d = 68'(r2 - {1'b0, y_q});
            acc_d = {acc_q[126:0], 1'b1};
          end else begin
            rem_d = 68'(r2);
            acc_d = {acc_q[126:0], 1'b0};
          end
          x_d = x_q << 1;
        end
        OP_SQRT: begin
          if (r4 >= trial) begin
            rem_d = r4 - trial;
            acc_d = {acc_q[126:0], 1'b1};
          end else begin
            rem_d = r4;
            acc_d = {acc_q[126:0], 1'b0};
          end
          x_d = x_q << 2;
        end
        default: ;
      endcase
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = (req_i.op == OP_DIV) ? 7'd127 : 7'd63;
      acc_d  = '0;
      rem_d  = '0;
      x_d    = req_i.a;
      y_d    = req_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    rem_q <= rem_d;
  end

  assign res_o.done  = done_q;
  assign res_o.value = acc_q;

endmodule

`default_nettype wire

### src/pdi_seq.sv
// Sequencer and particle state: steps each request through the shared unit.
// Depends on pdi_pkg; drives pdi_alu.
`timescale 1ns / 1ps
`default_nettype none

module pdi_seq
  import pdi_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     item_valid_i,
  output logic          item_ready_o,
  input  wire item_t    item_i,
  output logic          res_valid_o,
  input  wire logic     res_free_i,
  output result_t       res_o,
  output alu_req_t      alu_req_o,
  input  wire alu_res_t alu_res_i
);

  seq_state_e   state_q, state_d;
  logic         go_q, go_d;
  logic         ay_q, ay_d;
  logic         sgn_q, sgn_d;
  logic         clip_q, clip_d;
  act_e         act_q, act_d;
  logic [31:0]  vin_q, vin_d;
  logic [31:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [31:0]  vel_x_q, vel_x_d, vel_y_q, vel_y_d;
  logic [31:0]  frc_x_q, frc_x_d, frc_y_q, frc_y_d;
  logic [30:0]  term_x_q, term_x_d, term_y_q, term_y_d;
  logic [31:0]  k_q, k_d;
  logic [31:0]  d_q, d_d;
  logic [127:0] num_q, num_d;
  logic [47:0]  ke_q, ke_d;
  logic [30:0]  meff;

  assign meff = (cfg_i.mass == '0) ? 31'd1 : cfg_i.mass;

  always_comb begin
    logic [127:0] res;
    logic [127:0] prod_q;
    logic [31:0]  v;
    wres_t        tw;
    wres_t        sw;
    logic         done;
    res    = alu_res_i.value;
    prod_q = res >> FRAC_BITS;
    done   = go_q && alu_res_i.done;
    v      = ay_q ? vel_y_q : vel_x_q;
    tw     = '0;
    sw     = '0;

    state_d  = state_q;
    go_d     = go_q;
    ay_d     = ay_q;
    sgn_d    = sgn_q;
    clip_d   = clip_q;
    act_d    = act_q;
    vin_d    = vin_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    vel_x_d  = vel_x_q;
    vel_y_d  = vel_y_q;
    frc_x_d  = frc_x_q;
    frc_y_d  = frc_y_q;
    term_x_d = term_x_q;
    term_y_d = term_y_q;
    k_d      = k_q;
    d_d      = d_q;
    num_d    = num_q;
    ke_d     = ke_q;

    item_ready_o    = 1'b0;
    res_valid_o     = 1'b0;
    alu_req_o.start = 1'b0;
    alu_req_o.op    = OP_MUL;
    alu_req_o.a     = '0;
    alu_req_o.b     = '0;

    if (done) go_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          act_d  = item_i.action;
          vin_d  = item_i.value_x;
          clip_d = 1'b0;
          ay_d   = 1'b0;
          state_d = S_E1;
          case (item_i.action)
            ACT_TICK, ACT_SETTERM: state_d = S_K1;
            ACT_KICK: state_d = S_KAX;
            ACT_ADD: begin
              tw = sat_add(frc_x_q, item_i.value_x);
              sw = sat_add(frc_y_q, item_i.value_y);
              frc_x_d = tw.w;
              frc_y_d = sw.w;
              clip_d  = tw.c | sw.c;
            end
            ACT_CLEAR: begin
              if (item_i.clear_mask[0]) frc_x_d = '0;
              if (item_i.clear_mask[1]) frc_y_d = '0;
            end
            ACT_SETPOS: begin
              pos_x_d = item_i.value_x;
              pos_y_d = item_i.value_y;
            end
            ACT_SETVEL: begin
              vel_x_d = item_i.value_x;
              vel_y_d = item_i.value_y;
            end
            default: ;
          endcase
        end
      end

      // k = (drag * density) * area
      S_K1: begin
        alu_req_o.a = 128'(cfg_i.drag);
        alu_req_o.b = 64'(cfg_i.density);
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          tw = to_word(1'b0, prod_q);
          k_d = tw.w;
          clip_d = clip_q | tw.c;
          state_d = S_K2;
        end
      end
      S_K2: begin
        alu_req_o.a = 128'(k_q);
        alu_req_o.b = 64'(cfg_i.area);
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          tw = to_word(1'b0, prod_q);
          k_d = tw.w;
          clip_d = clip_q | tw.c;
          state_d = (act_q == ACT_SETTERM) ? S_XN : S_DS;
        end
      end

      // drag on the axis picked by ay_q
      S_DS: begin
        alu_req_o.a = 128'(mag(v));
        alu_req_o.b = 64'(mag(v));
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          num_d = prod_q;
          state_d = S_DM;
        end
      end
      S_DM: begin
        alu_req_o.a = 128'(k_q);
        alu_req_o.b = num_q[63:0];
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          num_d = res;
          state_d = S_DD;
        end
      end
      S_DD: begin
        alu_req_o.op = OP_DIV;
        alu_req_o.a  = num_q;
        alu_req_o.b  = 64'({meff, 1'b0});
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          tw = to_word(1'b0, res);
          clip_d = clip_q | tw.c;
          d_d = v[31] ? tw.w : (32'd0 - tw.w);
          state_d = ay_q ? S_VY : S_VX;
        end
      end

      // vel += d * dt
      S_VX: begin
        alu_req_o.a = 128'(mag(d_q));
        alu_req_o.b = 64'(cfg_i.tstep);
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          tw = to_word(d_q[31], prod_q);
          sw = sat_add(vel_x_q, tw.w);
          vel_x_d = sw.w;
          clip_d = clip_q | tw.c | sw.c;
          if (act_q == ACT_KICK) begin
            state_d = S_KAY;
          end else if (term_y_q == '0) begin
            state_d = S_TY0;
          end else begin
            ay_d = 1'b1;
            state_d = S_DS;
          end
        end
      end
      S_VY: begin
        sw = sat_add(cfg_i.gravity, d_q);
        alu_req_o.a = 128'(mag(sw.w));
        alu_req_o.b = 64'(cfg_i.tstep);
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
          sgn_d = sw.w[31];
          clip_d = clip_q | sw.c;
        end else if (done) begin
          tw = to_word(sgn_q, prod_q);
          sw = sat_add(vel_y_q, tw.w);
          vel_y_d = sw.w;
          clip_d = clip_q | tw.c | sw.c;
          state_d = (act_q == ACT_KICK) ? S_E1 : S_PX;
        end
      end

      S_PX: begin
        alu_req_o.a = 128'(mag(vel_x_q));
        alu_req_o.b = 64'(cfg_i.tstep);
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          tw = to_word(vel_x_q[31], prod_q);
          sw = sat_add(pos_x_q, tw.w);
          pos_x_d = sw.w;
          clip_d = clip_q | tw.c | sw.c;
          state_d = S_PY;
        end
      end
      S_PY: begin
        alu_req_o.a = 128'(mag(vel_y_q));
        alu_req_o.b = 64'(cfg_i.tstep);
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          tw = to_word(vel_y_q[31], prod_q);
          sw = sat_add(pos_y_q, tw.w);
          pos_y_d = sw.w;
          clip_d = clip_q | tw.c | sw.c;
          state_d = S_E1;
        end
      end

      // kick: a = F / m
      S_KAX: begin
        alu_req_o.op = OP_DIV;
        alu_req_o.a  = 128'({mag(frc_x_q), 16'd0});
        alu_req_o.b  = 64'(meff);
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          tw = to_word(frc_x_q[31], res);
          d_d = tw.w;
          clip_d = clip_q | tw.c;
          state_d = S_VX;
        end
      end
      S_KAY: begin
        alu_req_o.op = OP_DIV;
        alu_req_o.a  = 128'({mag(frc_y_q), 16'd0});
        alu_req_o.b  = 64'(meff);
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          tw = to_word(frc_y_q[31], res);
          d_d = tw.w;
          clip_d = clip_q | tw.c;
          state_d = S_VY;
        end
      end

      // terminal y = sqrt(2*m*g/k)
      S_TY0: begin
        alu_req_o.a = 128'(meff);
        alu_req_o.b = 64'(cfg_i.gravity);
        if (!go_q) begin
          if (cfg_i.gravity[31] || cfg_i.gravity == '0) begin
            term_y_d = '0;
            ay_d = 1'b1;
            state_d = (act_q == ACT_SETTERM) ? S_E1 : S_DS;
          end else begin
            alu_req_o.start = 1'b1;
            go_d = 1'b1;
          end
        end else if (done) begin
          num_d = res << 1;
          state_d = S_TY1;
        end
      end
      S_TY1: begin
        alu_req_o.op = OP_DIV;
        alu_req_o.a  = num_q;
        alu_req_o.b  = 64'(k_q);
        if (!go_q) begin
          if (k_q == '0) begin
            clip_d = 1'b1;
            term_y_d = WMAX;
            ay_d = 1'b1;
            state_d = (act_q == ACT_SETTERM) ? S_E1 : S_DS;
          end else begin
            alu_req_o.start = 1'b1;
            go_d = 1'b1;
          end
        end else if (done) begin
          if (|res[127:111]) begin
            clip_d = 1'b1;
            term_y_d = WMAX;
            ay_d = 1'b1;
            state_d = (act_q == ACT_SETTERM) ? S_E1 : S_DS;
          end else begin
            num_d = res << FRAC_BITS;
            state_d = S_TY2;
          end
        end
      end
      S_TY2: begin
        alu_req_o.op = OP_SQRT;
        alu_req_o.a  = num_q;
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          if (|res[127:31]) begin
            clip_d = 1'b1;
            term_y_d = WMAX;
          end else begin
            term_y_d = res[30:0];
          end
          ay_d = 1'b1;
          state_d = (act_q == ACT_SETTERM) ? S_E1 : S_DS;
        end
      end

      // terminal x = sqrt(2*m*|v|*2^F / (dt*k) * 2^F)
      S_XN: begin
        alu_req_o.a = 128'(meff);
        alu_req_o.b = 64'(mag(vin_q));
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          num_d = res << (FRAC_BITS + 1);
          if (res == '0) begin
            term_x_d = '0;
            state_d = S_TY0;
          end else if (cfg_i.tstep == '0 || k_q == '0) begin
            clip_d = 1'b1;
            term_x_d = WMAX;
            state_d = S_TY0;
          end else begin
            state_d = S_XD1;
          end
        end
      end
      S_XD1: begin
        alu_req_o.op = OP_DIV;
        alu_req_o.a  = num_q;
        alu_req_o.b  = 64'(cfg_i.tstep);
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          num_d = res;
          state_d = S_XD2;
        end
      end
      S_XD2: begin
        alu_req_o.op = OP_DIV;
        alu_req_o.a  = num_q;
        alu_req_o.b  = 64'(k_q);
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          if (|res[127:111]) begin
            clip_d = 1'b1;
            term_x_d = WMAX;
            state_d = S_TY0;
          end else begin
            num_d = res << FRAC_BITS;
            state_d = S_XSQ;
          end
        end
      end
      S_XSQ: begin
        alu_req_o.op = OP_SQRT;
        alu_req_o.a  = num_q;
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          if (|res[127:31]) begin
            clip_d = 1'b1;
            term_x_d = WMAX;
          end else begin
            term_x_d = res[30:0];
          end
          state_d = S_TY0;
        end
      end

      // kinetic energy
      S_E1: begin
        alu_req_o.a = 128'(mag(vel_x_q));
        alu_req_o.b = 64'(mag(vel_x_q));
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          num_d = res;
          state_d = S_E2;
        end
      end
      S_E2: begin
        alu_req_o.a = 128'(mag(vel_y_q));
        alu_req_o.b = 64'(mag(vel_y_q));
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          num_d = (num_q + res) >> FRAC_BITS;
          state_d = S_E3;
        end
      end
      S_E3: begin
        alu_req_o.a = 128'(meff);
        alu_req_o.b = num_q[63:0];
        if (!go_q) begin
          alu_req_o.start = 1'b1;
          go_d = 1'b1;
        end else if (done) begin
          num_d = res >> (FRAC_BITS + 1);
          if (|num_d[127:KE_BITS]) begin
            clip_d = 1'b1;
            ke_d = '1;
          end else begin
            ke_d = num_d[KE_BITS-1:0];
          end
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_free_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      go_q     <= 1'b0;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      vel_x_q  <= '0;
      vel_y_q  <= '0;
      frc_x_q  <= '0;
      frc_y_q  <= '0;
      term_x_q <= '0;
      term_y_q <= '0;
    end else begin
      state_q  <= state_d;
      go_q     <= go_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      vel_x_q  <= vel_x_d;
      vel_y_q  <= vel_y_d;
      frc_x_q  <= frc_x_d;
      frc_y_q  <= frc_y_d;
      term_x_q <= term_x_d;
      term_y_q <= term_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ay_q   <= ay_d;
    sgn_q  <= sgn_d;
    clip_q <= clip_d;
    act_q  <= act_d;
    vin_q  <= vin_d;
    k_q    <= k_d;
    d_q    <= d_d;
    num_q  <= num_d;
    ke_q   <= ke_d;
  end

  assign res_o.position_x     = pos_x_q;
  assign res_o.position_y     = pos_y_q;
  assign res_o.velocity_x     = vel_x_q;
  assign res_o.velocity_y     = vel_y_q;
  assign res_o.terminal_x     = term_x_q;
  assign res_o.terminal_y     = term_y_q;
  assign res_o.kinetic_energy = ke_q;
  assign res_o.saturated      = clip_q;

endmodule

`default_nettype wire

### src/pdi_checker.sv
// Port-level checker for the particle drag integrator, bound to the top level.
// Depends on particle_drag_integrator_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "particle_drag_integrator_top_defines.svh"

module pdi_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [239:0] m_axis_tdata
);

  `PDI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `PDI_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after a request")
  `PDI_ASSERT_NOW(a_ke_at_rest, m_axis_tvalid && m_axis_tdata[127:64] == 64'd0, m_axis_tdata[237:190] == 48'd0, "energy nonzero at rest")

endmodule

bind particle_drag_integrator_top pdi_checker u_pdi_checker (.*);

`default_nettype wire
